>>> hdl/e2c_pkg.sv
`default_nettype none
package e2c_pkg;

   // Timestamp bits taken from the input word.
   localparam int TIME_BITS = 34;
   localparam int ZONE_W    = 17;

   // Adjusted time is non-negative and below 2^(TIME_BITS+1).
   localparam int ADJ_W  = TIME_BITS + 1;
   localparam int SADJ_W = TIME_BITS + 2;

   localparam int SECS_PER_DAY  = 86400;
   localparam int DAYS_PER_400Y = 146097;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int DST_SECS      = 3600;
   localparam int EPOCH_YEAR    = 1970;
   localparam int YEAR_BASE     = 1900;
   localparam int EPOCH_WEEKDAY = 4;

   localparam int REM_W = $clog2(2 * SECS_PER_DAY);

   localparam longint MAX_DAYS   = ((64'd1 << ADJ_W) - 64'd1) / 64'd86400;
   localparam int     DAYS_RAW_W = $clog2(MAX_DAYS + 64'd1);
   localparam int     DAYS_W     = (DAYS_RAW_W > 18) ? DAYS_RAW_W : 18;
   localparam int     YEAR_W     =
      $clog2(64'd1970 + 64'd400 * (MAX_DAYS / 64'd146097) + 64'd400);

   // The day length is 675 times 128: the low seven bits of the time go straight into the
   // remainder and the rest is divided by 675 with a reciprocal multiply.
   localparam int DAY_SHIFT   = 7;
   localparam int DAY_ODD     = 675;
   localparam int ODD_W       = $clog2(DAY_ODD);
   localparam int QUOT_W      = ADJ_W - DAY_SHIFT;
   localparam int RECIP_SHIFT = QUOT_W + ODD_W;
   localparam int RECIP_W     = RECIP_SHIFT - ODD_W + 1;
   localparam int PROD_W      = QUOT_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_DAY =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd675);

   // Octal digits of the day count, summed for the weekday residue.
   localparam int WK_DIGITS = (DAYS_W + 2) / 3;
   localparam int WK_PAD_W  = 3 * WK_DIGITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [TIME_BITS-1:0] timestamp;
      logic                 dst_active;
   } req_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] weekday;
      logic [9:0] year_since_1900;
      logic [3:0] month;
      logic [4:0] day_of_month;
      logic [8:0] day_of_year;
      logic       dst_echo;
      logic       clamped;
   } rsp_type;

   // What the front end hands over for conversion.
   typedef struct packed {
      logic [ADJ_W-1:0] seconds;
      logic             dst;
      logic             clamped;
   } work_type;

   function automatic logic [4:0] month_len(input logic [3:0] mon);
      logic [4:0] len;
      unique case (mon)
         4'd1:                     len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

>>> hdl/e2c_front.sv
`default_nettype none
module e2c_front
   import e2c_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [ZONE_W-1:0] csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   push,
   input  wire logic              queue_full,
   output work_type               push_data
);

   logic signed [ZONE_W-1:0] zone_ff;
   logic signed [ZONE_W-1:0] zone_in;
   logic signed [SADJ_W-1:0] adj;

   always_comb begin
      zone_in = csr_write_enable ? signed'(csr_write_data) : zone_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= '0;
      end else begin
         zone_ff <= zone_in;
      end
   end

   always_comb begin
      adj = signed'({2'b00, req_data.timestamp}) - SADJ_W'(zone_ff)
            + (req_data.dst_active ? SADJ_W'(DST_SECS) : SADJ_W'(0));
      push_data.dst = req_data.dst_active;
      if (adj[SADJ_W-1]) begin
         push_data.seconds = '0;
         push_data.clamped = 1'b1;
      end else begin
         push_data.seconds = adj[ADJ_W-1:0];
         push_data.clamped = 1'b0;
      end
      req_stall = queue_full;
      push      = req_valid && !queue_full;
   end

endmodule
`default_nettype wire

>>> hdl/e2c_queue.sv
`default_nettype none
module e2c_queue
   import e2c_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output work_type      pop_data
);

   work_type            store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   always_comb begin
      full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
      not_empty = (fill_ff != '0);
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      pop_data  = store_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> hdl/e2c_back.sv
`default_nettype none
module e2c_back
   import e2c_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     not_empty,
   input  wire work_type pop_data,
   output logic          pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIV   = 4'd1;
   localparam logic [3:0] ST_HOUR  = 4'd2;
   localparam logic [3:0] ST_MIN   = 4'd3;
   localparam logic [3:0] ST_CYC   = 4'd4;
   localparam logic [3:0] ST_YEAR  = 4'd5;
   localparam logic [3:0] ST_MON   = 4'd6;
   localparam logic [3:0] ST_DONE  = 4'd7;
   localparam logic [3:0] ST_FIX   = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [ADJ_W-1:0]  t_ff, t_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DAYS_W-1:0] days_ff, days_in;
   logic [2:0]        wk_ff, wk_in;
   logic [4:0]        hour_ff, hour_in;
   logic [5:0]        minute_ff, minute_in;
   logic [YEAR_W-1:0] year_ff, year_in;
   logic [6:0]        mod100_ff, mod100_in;
   logic [8:0]        mod400_ff, mod400_in;
   logic [8:0]        yday_ff, yday_in;
   logic [3:0]        mon_ff, mon_in;
   logic              dst_ff, dst_in;
   logic              clamped_ff, clamped_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [QUOT_W-1:0]   quot_src;
   logic [PROD_W-1:0]   product;
   logic [QUOT_W-1:0]   odd_rem;
   logic                odd_over;
   logic [QUOT_W-1:0]   odd_fix;
   logic [WK_PAD_W-1:0] days_pad;
   logic [7:0]          digit_sum;
   logic [3:0]          wk_fold;
   logic [2:0]          wk_mod;
   logic                leap;
   logic [8:0]          ylen;
   logic [4:0]          mlen;
   logic [2:0]          wk_sum;
   logic [YEAR_W-1:0]   year_rel;

   always_comb begin
      // Leap rule from the running residues: year mod 4 is the low two bits.
      leap = (year_ff[1:0] == 2'b00) && ((mod100_ff != '0) || (mod400_ff == '0));
      ylen = leap ? 9'd366 : 9'd365;
      mlen = month_len(mon_ff) + ((mon_ff == 4'd1 && leap) ? 5'd1 : 5'd0);

      // The reciprocal estimate of the day count is never high and at most one short.
      quot_src = t_ff[ADJ_W-1:DAY_SHIFT];
      product  = PROD_W'(quot_src) * PROD_W'(RECIP_DAY);
      odd_rem  = quot_src - QUOT_W'(days_ff) * QUOT_W'(DAY_ODD);
      odd_over = (odd_rem >= QUOT_W'(DAY_ODD));
      odd_fix  = odd_over ? odd_rem - QUOT_W'(DAY_ODD) : odd_rem;

      // Eight is one more than seven, so the octal digit sum keeps the residue mod 7.
      days_pad  = WK_PAD_W'(days_ff);
      digit_sum = '0;
      for (int i = 0; i < WK_DIGITS; i++) begin
         digit_sum = digit_sum + 8'(days_pad[3*i +: 3]);
      end
      wk_fold = {1'b0, digit_sum[5:3]} + {1'b0, digit_sum[2:0]};
      wk_mod  = (wk_fold >= 4'd14) ? 3'(wk_fold - 4'd14) :
                (wk_fold >= 4'd7)  ? 3'(wk_fold - 4'd7)  : wk_fold[2:0];

      wk_sum   = (wk_ff >= 3'd3) ? wk_ff - 3'd3 : wk_ff + 3'd4;
      year_rel = year_ff - YEAR_W'(YEAR_BASE);

      state_in     = state_ff;
      t_in         = t_ff;
      rem_in       = rem_ff;
      days_in      = days_ff;
      wk_in        = wk_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      year_in      = year_ff;
      mod100_in    = mod100_ff;
      mod400_in    = mod400_ff;
      yday_in      = yday_ff;
      mon_in       = mon_ff;
      dst_in       = dst_ff;
      clamped_in   = clamped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               pop        = 1'b1;
               t_in       = pop_data.seconds;
               dst_in     = pop_data.dst;
               clamped_in = pop_data.clamped;
               rem_in     = '0;
               days_in    = '0;
               wk_in      = '0;
               hour_in    = '0;
               minute_in  = '0;
               year_in    = YEAR_W'(EPOCH_YEAR);
               mod100_in  = 7'(EPOCH_YEAR % 100);
               mod400_in  = 9'(EPOCH_YEAR % 400);
               mon_in     = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            days_in  = DAYS_W'(product >> RECIP_SHIFT);
            state_in = ST_FIX;
         end
         ST_FIX: begin
            days_in  = days_ff + DAYS_W'(odd_over);
            rem_in   = REM_W'({odd_fix[ODD_W-1:0], t_ff[DAY_SHIFT-1:0]});
            state_in = ST_HOUR;
         end
         ST_HOUR: begin
            wk_in = wk_mod;
            if (rem_ff >= REM_W'(SECS_PER_HOUR)) begin
               rem_in  = rem_ff - REM_W'(SECS_PER_HOUR);
               hour_in = hour_ff + 1'b1;
            end else begin
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            if (rem_ff >= REM_W'(SECS_PER_MIN)) begin
               rem_in    = rem_ff - REM_W'(SECS_PER_MIN);
               minute_in = minute_ff + 1'b1;
            end else begin
               state_in = ST_CYC;
            end
         end
         ST_CYC: begin
            // A full 400-year cycle leaves every leap residue unchanged.
            if (days_ff >= DAYS_W'(DAYS_PER_400Y)) begin
               days_in = days_ff - DAYS_W'(DAYS_PER_400Y);
               year_in = year_ff + YEAR_W'(400);
            end else begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (days_ff < DAYS_W'(ylen)) begin
               yday_in  = days_ff[8:0];
               state_in = ST_MON;
            end else begin
               days_in   = days_ff - DAYS_W'(ylen);
               year_in   = year_ff + 1'b1;
               mod100_in = (mod100_ff == 7'd99) ? '0 : mod100_ff + 1'b1;
               mod400_in = (mod400_ff == 9'd399) ? '0 : mod400_ff + 1'b1;
            end
         end
         ST_MON: begin
            if (days_ff < DAYS_W'(mlen) || mon_ff == 4'd11) begin
               state_in = ST_DONE;
            end else begin
               days_in = days_ff - DAYS_W'(mlen);
               mon_in  = mon_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.second          = rem_ff[5:0];
               rsp_data_in.minute          = minute_ff;
               rsp_data_in.hour            = hour_ff;
               rsp_data_in.weekday         = wk_sum;
               rsp_data_in.year_since_1900 = year_rel[9:0];
               rsp_data_in.month           = mon_ff;
               rsp_data_in.day_of_month    = days_ff[4:0] + 5'd1;
               rsp_data_in.day_of_year     = yday_ff;
               rsp_data_in.dst_echo        = dst_ff;
               rsp_data_in.clamped         = clamped_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      rem_ff      <= rem_in;
      days_ff     <= days_in;
      wk_ff       <= wk_in;
      hour_ff     <= hour_in;
      minute_ff   <= minute_in;
      year_ff     <= year_in;
      mod100_ff   <= mod100_in;
      mod400_ff   <= mod400_in;
      yday_ff     <= yday_in;
      mon_ff      <= mon_in;
      dst_ff      <= dst_in;
      clamped_ff  <= clamped_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

>>> hdl/epoch_to_calendar_time.sv
// Flow: the front end writes each word into the queue; the converter then divides by the
// day, walks hours, minutes, 400-year cycles, years and months, and registers the result.
// A new word is taken only after the last is converted; the year walk (up to 399 years) dominates.
// The front end keeps accepting while the queue (two words) has room.
// Synchronous active-high reset clears all control state and the zone offset register.
`default_nettype none
module epoch_to_calendar_time
   import e2c_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [ZONE_W-1:0] csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data
);

   logic     push;
   logic     queue_full;
   work_type push_data;
   logic     pop;
   logic     not_empty;
   work_type pop_data;

   e2c_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .push             (push),
      .queue_full       (queue_full),
      .push_data        (push_data)
   );

   e2c_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   e2c_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> hdl/e2c_checker.sv
`default_nettype none
module e2c_checker
   import e2c_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled word stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid directly after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.second < 6'd60 && rsp_data.minute < 6'd60
                    && rsp_data.hour < 5'd24 && rsp_data.weekday < 3'd7)
      else $error("time of day or weekday out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.month < 4'd12 && rsp_data.day_of_month != 5'd0
                    && rsp_data.day_of_year < 9'd366)
      else $error("date field out of range");

   // A clamped word is always the epoch itself, a Thursday.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clamped |-> rsp_data.second == 6'd0
         && rsp_data.minute == 6'd0 && rsp_data.hour == 5'd0 && rsp_data.weekday == 3'd4
         && rsp_data.year_since_1900 == 10'd70 && rsp_data.day_of_year == 9'd0)
      else $error("clamped word is not the epoch");

endmodule

bind epoch_to_calendar_time e2c_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

>>> dv/tb_epoch_to_calendar_time.sv
`default_nettype none
module tb_epoch_to_calendar_time;
   timeunit 1ns;
   timeprecision 1ps;
   import e2c_pkg::*;

   localparam longint MAX_TS          = (longint'(1) << TIME_BITS) - 1;
   localparam longint FIRST_CYCLE_END = longint'(DAYS_PER_400Y) * SECS_PER_DAY;
   localparam int     HANG_LIMIT      = 20000;
   localparam int     SETTLE_CYCLES   = 600;
   localparam int     RANDOM_PHASES   = 5;
   localparam int     WORDS_PER_PHASE = 200;
   localparam int     QUIET_WORDS     = 100;

   class date_checker;
      logic signed [ZONE_W-1:0] zone_west;
      rsp_type                  pending_dates[$];
      int                       failures;
      int                       month_days[12];

      function new();
         zone_west  = '0;
         failures   = 0;
         month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      endfunction

      function int leap_days(longint year);
         if (year % 4 != 0) return 0;
         if (year % 100 != 0) return 1;
         if (year % 400 != 0) return 0;
         return 1;
      endfunction

      function rsp_type convert_epoch(req_type w);
         rsp_type d;
         longint  stamp;
         longint  zone;
         longint  adj;
         longint  days;
         longint  secs;
         longint  year;
         int      mon;
         bit      neg;
         stamp = w.timestamp;
         zone  = zone_west;
         adj   = stamp - zone + (w.dst_active ? DST_SECS : 0);
         neg   = adj < 0;
         if (neg) begin
            adj = 0;
         end
         days = adj / SECS_PER_DAY;
         secs = adj % SECS_PER_DAY;
         d.second  = 6'(secs % SECS_PER_MIN);
         d.minute  = 6'((secs % SECS_PER_HOUR) / SECS_PER_MIN);
         d.hour    = 5'(secs / SECS_PER_HOUR);
         d.weekday = 3'((days + EPOCH_WEEKDAY) % 7);
         // Whole 400-year cycles are skipped at once, the remainder is walked.
         year = EPOCH_YEAR + 400 * (days / DAYS_PER_400Y);
         days = days % DAYS_PER_400Y;
         while (days >= 365 + leap_days(year)) begin
            days -= 365 + leap_days(year);
            year++;
         end
         d.day_of_year = 9'(days);
         mon = 0;
         while (mon < 11 && days >= month_days[mon] + ((mon == 1) ? leap_days(year) : 0)) begin
            days -= month_days[mon] + ((mon == 1) ? leap_days(year) : 0);
            mon++;
         end
         d.year_since_1900 = 10'(year - YEAR_BASE);
         d.month           = 4'(mon);
         d.day_of_month    = 5'(days + 1);
         d.dst_echo        = w.dst_active;
         d.clamped         = neg;
         return d;
      endfunction

      function string date_text(rsp_type d);
         return $sformatf("y%0d m%0d d%0d yday %0d %0d:%0d:%0d wday %0d dst %0b clamp %0b",
                          d.year_since_1900, d.month, d.day_of_month, d.day_of_year,
                          d.hour, d.minute, d.second, d.weekday, d.dst_echo, d.clamped);
      endfunction

      function void note_request(req_type w);
         pending_dates.push_back(convert_epoch(w));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_dates.size() == 0) begin
            if (failures < 10) begin
               $display("unexpected result word: %s", date_text(got));
            end
            failures++;
            return;
         end
         want = pending_dates.pop_front();
         if (got.second !== want.second || got.minute !== want.minute ||
             got.hour !== want.hour || got.weekday !== want.weekday ||
             got.year_since_1900 !== want.year_since_1900 || got.month !== want.month ||
             got.day_of_month !== want.day_of_month ||
             got.day_of_year !== want.day_of_year ||
             got.dst_echo !== want.dst_echo || got.clamped !== want.clamped) begin
            if (failures < 10) begin
               $display("mismatch: expected %s", date_text(want));
               $display("          actual   %s", date_text(got));
            end
            failures++;
         end
      endfunction
   endclass

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [ZONE_W-1:0] csr_write_data   = '0;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   req_type           req_data         = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   rsp_type           rsp_data;

   bit                quiet_tail  = 1'b0;
   int                idle_cycles = 0;
   int                day_marks[7] = '{0, 31, 58, 59, 60, 364, 365};
   date_checker       calendar = new();

   epoch_to_calendar_time u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_word(input longint stamp, input logic dst);
      req_type w;
      w.timestamp  = stamp[TIME_BITS-1:0];
      w.dst_active = dst;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      calendar.note_request(w);
   endtask

   // The zone register is only changed once every outstanding word has come back.
   task automatic load_zone(input logic signed [ZONE_W-1:0] zone);
      req_valid <= 1'b0;
      while (calendar.pending_dates.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= zone;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      calendar.zone_west = zone;
   endtask

   initial begin
      logic [63:0]              wide;
      logic signed [ZONE_W-1:0] zone;
      longint                   stamp;
      int                       pick;
      int                       year_pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      load_zone('0);
      send_word(0, 1'b0);
      send_word(0, 1'b1);
      send_word(MAX_TS, 1'b0);
      send_word(MAX_TS, 1'b1);
      send_word(86399, 1'b0);
      send_word(86400, 1'b0);
      send_word(64'd951782400, 1'b0);
      send_word(64'd951868799, 1'b0);
      send_word(64'd978307199, 1'b0);
      send_word(64'd4107542399, 1'b0);
      send_word(64'd4107542400, 1'b0);
      send_word(FIRST_CYCLE_END - 1, 1'b0);
      send_word(FIRST_CYCLE_END, 1'b0);
      send_word(64'd13574563200, 1'b1);

      // Furthest west: small timestamps fall below the epoch and are clamped.
      load_zone(ZONE_W'(50400));
      send_word(50399, 1'b0);
      send_word(50400, 1'b0);
      send_word(46799, 1'b1);
      send_word(46800, 1'b1);

      load_zone(ZONE_W'(-50400));
      send_word(0, 1'b0);
      send_word(MAX_TS, 1'b1);

      // Offsets beyond the stated range are taken as they stand.
      load_zone(ZONE_W'(-65536));
      send_word(MAX_TS, 1'b1);
      load_zone(ZONE_W'(65535));
      send_word(65534, 1'b0);
      send_word(65535, 1'b1);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1: begin
               zone = '0;
            end
            2: begin
               zone = ZONE_W'($urandom_range(0, 131071));
            end
            default: begin
               zone = ZONE_W'(int'($urandom_range(0, 100800)) - 50400);
            end
         endcase
         load_zone(zone);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (p == RANDOM_PHASES - 1 && n >= WORDS_PER_PHASE - QUIET_WORDS) begin
               quiet_tail = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick <= 4) begin
               wide  = {$urandom(), $urandom()};
               stamp = wide[TIME_BITS-1:0];
            end else if (pick == 5) begin
               stamp = $urandom_range(0, 120000);
            end else if (pick <= 7) begin
               // Land near the start or end of a year, or around the start or end of February.
               year_pick = $urandom_range(EPOCH_YEAR, 2513);
               stamp     = 0;
               for (int y = EPOCH_YEAR; y < year_pick; y++) begin
                  stamp += ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 366 : 365;
               end
               stamp = (stamp + day_marks[$urandom_range(0, 6)]) * SECS_PER_DAY
                       + int'($urandom_range(0, 180000)) - 90000;
            end else if (pick == 8) begin
               stamp = MAX_TS - int'($urandom_range(0, 200000));
            end else begin
               stamp = FIRST_CYCLE_END + int'($urandom_range(0, 200000)) - 100000;
            end
            if (stamp < 0) begin
               stamp = 0;
            end
            if (stamp > MAX_TS) begin
               stamp = MAX_TS;
            end
            send_word(stamp, 1'($urandom_range(0, 1)));
         end
      end

      req_valid <= 1'b0;
      while (calendar.pending_dates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (calendar.failures == 0 && calendar.pending_dates.size() == 0) begin
         $display("epoch_to_calendar_time test passed");
      end else begin
         $display("epoch_to_calendar_time test failed");
      end
      $finish;
   end

   // Receiver back-pressure: short stall bursts between longer open stretches.
   initial begin
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (quiet_tail) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         calendar.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("epoch_to_calendar_time test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
`default_nettype wire

>>> filelist.f
hdl/e2c_pkg.sv
hdl/e2c_front.sv
hdl/e2c_queue.sv
hdl/e2c_back.sv
hdl/epoch_to_calendar_time.sv
hdl/e2c_checker.sv
dv/tb_epoch_to_calendar_time.sv
